>>> rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg: shared types, constants and functions of the source tokenizer
// Holds the scan modes, the result record layout, the keyword table and the
// small character-class and operator decoding helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

   // Sizes of the design.
   localparam int MAX_KEYWORD_LEN = 8;
   localparam int LINE_BITS       = 16;
   localparam int NUMBER_BITS     = 31;
   localparam int NAME_LEN_BITS   = $clog2(MAX_KEYWORD_LEN + 1);
   localparam int NAME_IDX_BITS   = $clog2(MAX_KEYWORD_LEN);
   localparam int ACC_BITS        = NUMBER_BITS + 4;
   localparam int MAX_RESULTS     = 3;
   localparam int QUEUE_DEPTH     = 8;
   localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS       = $clog2(QUEUE_DEPTH + 1);
   localparam logic [NUMBER_BITS-1:0] NUMBER_MAX = '1;

   // Scan modes.
   typedef enum logic [3:0] {
      MODE_IDLE, MODE_IDENT, MODE_ZERO, MODE_DEC, MODE_REAL,
      MODE_HEX, MODE_OCT, MODE_BIN, MODE_STR, MODE_OP
   } mode_type;

   // Token kinds.
   localparam logic [3:0] KIND_IDENT   = 4'd0;
   localparam logic [3:0] KIND_KEYWORD = 4'd1;
   localparam logic [3:0] KIND_PARAM   = 4'd2;
   localparam logic [3:0] KIND_DECIMAL = 4'd3;
   localparam logic [3:0] KIND_REAL    = 4'd4;
   localparam logic [3:0] KIND_RADIX   = 4'd5;
   localparam logic [3:0] KIND_STRING  = 4'd6;
   localparam logic [3:0] KIND_OPER    = 4'd7;
   localparam logic [3:0] KIND_BRACKET = 4'd8;
   localparam logic [3:0] KIND_ASSIGN  = 4'd9;
   localparam logic [3:0] KIND_END     = 4'd10;
   localparam logic [3:0] KIND_UNKNOWN = 4'd11;

   // Operator codes.
   localparam logic [4:0] OP_LAND  = 5'd0;
   localparam logic [4:0] OP_AND   = 5'd1;
   localparam logic [4:0] OP_LOR   = 5'd2;
   localparam logic [4:0] OP_OR    = 5'd3;
   localparam logic [4:0] OP_DEC   = 5'd4;
   localparam logic [4:0] OP_MINUS = 5'd5;
   localparam logic [4:0] OP_INC   = 5'd6;
   localparam logic [4:0] OP_PLUS  = 5'd7;
   localparam logic [4:0] OP_POW   = 5'd8;
   localparam logic [4:0] OP_MUL   = 5'd9;
   localparam logic [4:0] OP_NE    = 5'd10;
   localparam logic [4:0] OP_NOT   = 5'd11;
   localparam logic [4:0] OP_LE    = 5'd12;
   localparam logic [4:0] OP_SHL   = 5'd13;
   localparam logic [4:0] OP_LT    = 5'd14;
   localparam logic [4:0] OP_GE    = 5'd15;
   localparam logic [4:0] OP_SHR   = 5'd16;
   localparam logic [4:0] OP_GT    = 5'd17;
   localparam logic [4:0] OP_DIV   = 5'd18;
   localparam logic [4:0] OP_MOD   = 5'd19;
   localparam logic [4:0] OP_TILDE = 5'd20;
   localparam logic [4:0] OP_XOR   = 5'd21;
   localparam logic [4:0] OP_EQ    = 5'd22;

   // Bracket codes.
   localparam logic [2:0] BR_LSQ  = 3'd0;
   localparam logic [2:0] BR_RSQ  = 3'd1;
   localparam logic [2:0] BR_LPAR = 3'd2;
   localparam logic [2:0] BR_RPAR = 3'd3;
   localparam logic [2:0] BR_LCUR = 3'd4;
   localparam logic [2:0] BR_RCUR = 3'd5;

   // Radix codes.
   localparam logic [1:0] RADIX_HEX = 2'd0;
   localparam logic [1:0] RADIX_OCT = 2'd1;
   localparam logic [1:0] RADIX_BIN = 2'd2;

   // Keyword table, left aligned, first character in the top byte.
   localparam int KW_COUNT = 20;
   localparam int KW_BYTES = 8;
   localparam logic [8*KW_BYTES-1:0] KW_TEXT [KW_COUNT] = '{
      {"defclass"}, {"defun", 24'h0}, {"if", 48'h0}, {"for", 40'h0},
      {"try", 40'h0}, {"while", 24'h0}, {"elif", 32'h0}, {"catch", 24'h0},
      {"else", 32'h0}, {"endif", 24'h0}, {"endfor", 16'h0}, {"endtry", 16'h0},
      {"endwhile"}, {"endclass"}, {"endfun", 16'h0}, {"in", 48'h0},
      {"var", 40'h0}, {"isa", 40'h0}, {"return", 16'h0}, {"break", 24'h0}
   };
   localparam int KW_LEN [KW_COUNT] = '{
      8, 5, 2, 3, 3, 5, 4, 5, 4, 5, 6, 6, 8, 8, 6, 2, 3, 3, 6, 5
   };

   // One result item.
   typedef struct packed {
      logic                   is_token_end;
      logic [7:0]             text_byte;
      logic [3:0]             token_kind;
      logic [4:0]             keyword_index;
      logic [4:0]             operator_code;
      logic [2:0]             bracket_code;
      logic [NUMBER_BITS-1:0] number_value;
      logic [1:0]             radix_code;
      logic [LINE_BITS-1:0]   line_number;
      logic                   last;
   } result_type;

   // Results produced by one request.
   typedef struct packed {
      logic [1:0]                        count;
      result_type [MAX_RESULTS-1:0]      items;
   } push_type;

   function automatic result_type make_text(input logic [7:0] c);
      result_type r;
      r = '0;
      r.text_byte = c;
      return r;
   endfunction

   function automatic result_type make_record(input logic [3:0] kind,
                                              input logic [LINE_BITS-1:0] line);
      result_type r;
      r = '0;
      r.is_token_end = 1'b1;
      r.token_kind   = kind;
      r.line_number  = line;
      return r;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

   // Single-character form of a pending operator.
   function automatic logic [4:0] lone_code(input logic [7:0] f);
      logic [4:0] code;
      case (f)
         "&":     code = OP_AND;
         "|":     code = OP_OR;
         "-":     code = OP_MINUS;
         "+":     code = OP_PLUS;
         "*":     code = OP_MUL;
         "!":     code = OP_NOT;
         "<":     code = OP_LT;
         ">":     code = OP_GT;
         default: code = OP_LAND;
      endcase
      return code;
   endfunction

   // Two-character operator: returns {hit, code}.
   function automatic logic [5:0] pair_code(input logic [7:0] f, input logic [7:0] c);
      logic [5:0] r;
      case (f)
         "&":     r = {c == "&", OP_LAND};
         "|":     r = {c == "|", OP_LOR};
         "-":     r = {c == "-", OP_DEC};
         "+":     r = {c == "+", OP_INC};
         "*":     r = {c == "*", OP_POW};
         "!":     r = {c == "=", OP_NE};
         "=":     r = {c == "=", OP_EQ};
         "<":     r = {(c == "=") || (c == "<"), (c == "=") ? OP_LE : OP_SHL};
         ">":     r = {(c == "=") || (c == ">"), (c == "=") ? OP_GE : OP_SHR};
         default: r = {1'b0, OP_LAND};
      endcase
      return r;
   endfunction

   // Translation of a byte following a backslash in a string.
   function automatic logic [7:0] escape_value(input logic [7:0] c);
      logic [7:0] v;
      case (c)
         "a":     v = 8'd7;
         "b":     v = 8'd8;
         "e":     v = 8'd27;
         "f":     v = 8'd12;
         "n":     v = 8'd10;
         "r":     v = 8'd13;
         "t":     v = 8'd9;
         "v":     v = 8'd11;
         default: v = c;
      endcase
      return v;
   endfunction

   // Keyword lookup: returns {hit, index}; the lowest table index wins.
   function automatic logic [5:0] keyword_lookup(
      input logic [8*MAX_KEYWORD_LEN-1:0] name,
      input logic [NAME_LEN_BITS-1:0]     len,
      input logic                         too_long);
      logic [5:0] r;
      logic       ok;
      r = '0;
      for (int i = KW_COUNT - 1; i >= 0; i--) begin
         ok = (int'(len) == KW_LEN[i]);
         for (int j = 0; j < KW_BYTES; j++) begin
            if ((j < KW_LEN[i]) && (j < MAX_KEYWORD_LEN)) begin
               ok = ok && (name[8*j +: 8] == KW_TEXT[i][8*KW_BYTES-1-8*j -: 8]);
            end
         end
         if (ok && !too_long) begin
            r = {1'b1, 5'(i)};
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/stt_intf.sv
// ----------------------------------------------------------------------------
// stt_intf: request and response channels of the source tokenizer
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
`default_nettype none

interface stt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_input;

   modport source (output valid, output char_byte, output end_of_input, input ready);
   modport sink   (input valid, input char_byte, input end_of_input, output ready);
endinterface

interface stt_rsp_if import stt_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic                   is_token_end;
   logic [7:0]             text_byte;
   logic [3:0]             token_kind;
   logic [4:0]             keyword_index;
   logic [4:0]             operator_code;
   logic [2:0]             bracket_code;
   logic [NUMBER_BITS-1:0] number_value;
   logic [1:0]             radix_code;
   logic [LINE_BITS-1:0]   line_number;
   logic                   last;

   modport source (output valid, output is_token_end, output text_byte, output token_kind,
                   output keyword_index, output operator_code, output bracket_code,
                   output number_value, output radix_code, output line_number,
                   output last, input ready);
   modport sink   (input valid, input is_token_end, input text_byte, input token_kind,
                   input keyword_index, input operator_code, input bracket_code,
                   input number_value, input radix_code, input line_number,
                   input last, output ready);
endinterface

`default_nettype wire

>>> rtl/stt_lexer.sv
// ----------------------------------------------------------------------------
// stt_lexer: input register, scanner state and per-byte decision logic
// Each registered request is decoded combinationally into up to three
// results, which are handed to the response queue together with the state
// update.
`default_nettype none

module stt_lexer import stt_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   stt_req_if.sink       req_chan,
   input  wire logic     room,
   output push_type      push
);

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] char_ff, char_in;
   logic       eoi_ff, eoi_in;
   logic       advance;

   // Scanner state.
   mode_type                     mode_ff, mode_in;
   logic [8*MAX_KEYWORD_LEN-1:0] nbuf_ff, nbuf_in;
   logic [NAME_LEN_BITS-1:0]     nlen_ff, nlen_in;
   logic                         long_ff, long_in;
   logic [NUMBER_BITS-1:0]       acc_ff, acc_in;
   logic [LINE_BITS-1:0]         line_ff, line_in;
   logic [7:0]                   quote_ff, quote_in;
   logic                         esc_ff, esc_in;
   logic [7:0]                   fop_ff, fop_in;

   // Decode results.
   result_type [MAX_RESULTS-1:0] res;
   logic [2:0]                   cnt;
   logic                         do_close, do_start;
   logic [ACC_BITS-1:0]          sum;
   logic [5:0]                   kw;
   logic [5:0]                   pair;
   logic [7:0]                   c;
   result_type                   r;

   // The request register moves on whenever the queue has room for a full set.
   assign advance        = in_valid_ff && room;
   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      char_in     = char_ff;
      eoi_in      = eoi_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
         char_in     = req_chan.char_byte;
         eoi_in      = req_chan.end_of_input;
      end
   end

   // Per-byte decode: continue the open token, close it, then start a new one.
   always_comb begin
      mode_in  = mode_ff;
      nbuf_in  = nbuf_ff;
      nlen_in  = nlen_ff;
      long_in  = long_ff;
      acc_in   = acc_ff;
      line_in  = line_ff;
      quote_in = quote_ff;
      esc_in   = esc_ff;
      fop_in   = fop_ff;
      res      = '0;
      cnt      = '0;
      do_close = 1'b0;
      do_start = 1'b0;
      c        = char_ff;
      r        = '0;
      sum      = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) + ACC_BITS'(c - "0");
      kw       = keyword_lookup(nbuf_ff, nlen_ff, long_ff);
      pair     = pair_code(fop_ff, c);

      if (eoi_ff) begin
         do_close = 1'b1;
      end else begin
         case (mode_ff)
            MODE_IDENT: begin
               if (is_alpha(c) || is_digit(c)) begin
                  res[cnt[1:0]] = make_text(c);
                  cnt = cnt + 3'd1;
                  if (int'(nlen_ff) < MAX_KEYWORD_LEN) begin
                     nbuf_in[8*nlen_ff[NAME_IDX_BITS-1:0] +: 8] = c;
                     nlen_in = nlen_ff + NAME_LEN_BITS'(1);
                  end else begin
                     long_in = 1'b1;
                  end
               end else if (c == ":") begin
                  res[cnt[1:0]] = make_text(c);
                  cnt = cnt + 3'd1;
                  res[cnt[1:0]] = make_record(KIND_PARAM, line_ff);
                  cnt = cnt + 3'd1;
                  mode_in = MODE_IDLE;
               end else begin
                  do_close = 1'b1;
                  do_start = 1'b1;
               end
            end
            MODE_ZERO: begin
               if (c == "x") begin
                  res[cnt[1:0]] = make_text(c);
                  cnt = cnt + 3'd1;
                  mode_in = MODE_HEX;
               end else if (c == "b") begin
                  res[cnt[1:0]] = make_text(c);
                  cnt = cnt + 3'd1;
                  mode_in = MODE_BIN;
               end else if ((c >= "0") && (c <= "7")) begin
                  res[cnt[1:0]] = make_text(c);
                  cnt = cnt + 3'd1;
                  mode_in = MODE_OCT;
               end else if (c == ".") begin
                  res[cnt[1:0]] = make_text(c);
                  cnt = cnt + 3'd1;
                  mode_in = MODE_REAL;
               end else begin
                  do_close = 1'b1;
                  do_start = 1'b1;
               end
            end
            MODE_DEC: begin
               if (is_digit(c)) begin
                  res[cnt[1:0]] = make_text(c);
                  cnt = cnt + 3'd1;
                  // Saturate once the value would pass the largest number.
                  if (sum > ACC_BITS'(NUMBER_MAX)) begin
                     acc_in = NUMBER_MAX;
                  end else begin
                     acc_in = sum[NUMBER_BITS-1:0];
                  end
               end else if (c == ".") begin
                  res[cnt[1:0]] = make_text(c);
                  cnt = cnt + 3'd1;
                  mode_in = MODE_REAL;
               end else begin
                  do_close = 1'b1;
                  do_start = 1'b1;
               end
            end
            MODE_REAL, MODE_HEX, MODE_OCT, MODE_BIN: begin
               if (((mode_ff == MODE_REAL) && is_digit(c)) ||
                   ((mode_ff == MODE_HEX) && is_hex(c)) ||
                   ((mode_ff == MODE_OCT) && (c >= "0") && (c <= "7")) ||
                   ((mode_ff == MODE_BIN) && ((c == "0") || (c == "1")))) begin
                  res[cnt[1:0]] = make_text(c);
                  cnt = cnt + 3'd1;
               end else begin
                  do_close = 1'b1;
                  do_start = 1'b1;
               end
            end
            MODE_STR: begin
               if (esc_ff) begin
                  esc_in = 1'b0;
                  res[cnt[1:0]] = make_text(escape_value(c));
                  cnt = cnt + 3'd1;
               end else if (c == quote_ff) begin
                  res[cnt[1:0]] = make_record(KIND_STRING, line_ff);
                  cnt = cnt + 3'd1;
                  mode_in = MODE_IDLE;
               end else if ((quote_ff == "\"") && (c == "\\")) begin
                  esc_in = 1'b1;
               end else begin
                  res[cnt[1:0]] = make_text(c);
                  cnt = cnt + 3'd1;
               end
            end
            MODE_OP: begin
               if (pair[5]) begin
                  r = make_record(KIND_OPER, line_ff);
                  r.operator_code = pair[4:0];
                  res[cnt[1:0]] = r;
                  cnt = cnt + 3'd1;
                  mode_in = MODE_IDLE;
               end else begin
                  do_close = 1'b1;
                  do_start = 1'b1;
               end
            end
            default: begin
               do_start = 1'b1;
            end
         endcase
      end

      // Close the open token.
      if (do_close) begin
         r = make_record(KIND_IDENT, line_ff);
         case (mode_ff)
            MODE_IDENT: begin
               if (kw[5]) begin
                  r.token_kind    = KIND_KEYWORD;
                  r.keyword_index = kw[4:0];
               end
               res[cnt[1:0]] = r;
               cnt = cnt + 3'd1;
            end
            MODE_ZERO, MODE_DEC: begin
               r.token_kind   = KIND_DECIMAL;
               r.number_value = acc_ff;
               res[cnt[1:0]] = r;
               cnt = cnt + 3'd1;
            end
            MODE_REAL: begin
               r.token_kind = KIND_REAL;
               res[cnt[1:0]] = r;
               cnt = cnt + 3'd1;
            end
            MODE_HEX, MODE_OCT, MODE_BIN: begin
               r.token_kind = KIND_RADIX;
               r.radix_code = (mode_ff == MODE_HEX) ? RADIX_HEX :
                              (mode_ff == MODE_OCT) ? RADIX_OCT : RADIX_BIN;
               res[cnt[1:0]] = r;
               cnt = cnt + 3'd1;
            end
            MODE_STR: begin
               if (esc_ff) begin
                  res[cnt[1:0]] = make_text("\\");
                  cnt = cnt + 3'd1;
               end
               r.token_kind = KIND_STRING;
               res[cnt[1:0]] = r;
               cnt = cnt + 3'd1;
            end
            MODE_OP: begin
               if (fop_ff == "=") begin
                  r.token_kind = KIND_ASSIGN;
               end else begin
                  r.token_kind    = KIND_OPER;
                  r.operator_code = lone_code(fop_ff);
               end
               res[cnt[1:0]] = r;
               cnt = cnt + 3'd1;
            end
            default: begin
            end
         endcase
         mode_in = MODE_IDLE;
         esc_in  = 1'b0;
      end

      // Start a new token with the current byte.
      if (do_start) begin
         mode_in = MODE_IDLE;
         r = make_record(KIND_BRACKET, line_ff);
         if (c == 8'd10) begin
            line_in = line_ff + LINE_BITS'(1);
         end else if (is_space(c)) begin
            mode_in = MODE_IDLE;
         end else begin
            case (c)
               "&", "|", "-", "+", "*", "!", "<", ">", "=": begin
                  fop_in  = c;
                  mode_in = MODE_OP;
               end
               "/", "%", "~", "^": begin
                  r.token_kind    = KIND_OPER;
                  r.operator_code = (c == "/") ? OP_DIV : (c == "%") ? OP_MOD :
                                    (c == "~") ? OP_TILDE : OP_XOR;
                  res[cnt[1:0]] = r;
                  cnt = cnt + 3'd1;
               end
               "[", "]", "(", ")", "{", "}": begin
                  r.bracket_code = (c == "[") ? BR_LSQ : (c == "]") ? BR_RSQ :
                                   (c == "(") ? BR_LPAR : (c == ")") ? BR_RPAR :
                                   (c == "{") ? BR_LCUR : BR_RCUR;
                  res[cnt[1:0]] = r;
                  cnt = cnt + 3'd1;
               end
               "\"", "'": begin
                  quote_in = c;
                  esc_in   = 1'b0;
                  mode_in  = MODE_STR;
               end
               default: begin
                  res[cnt[1:0]] = make_text(c);
                  cnt = cnt + 3'd1;
                  if (is_digit(c)) begin
                     acc_in  = NUMBER_BITS'(c - "0");
                     mode_in = (c == "0") ? MODE_ZERO : MODE_DEC;
                  end else if (is_alpha(c)) begin
                     nbuf_in[7:0] = c;
                     nlen_in      = NAME_LEN_BITS'(1);
                     long_in      = 1'b0;
                     mode_in      = MODE_IDENT;
                  end else begin
                     res[cnt[1:0]] = make_record(KIND_UNKNOWN, line_ff);
                     cnt = cnt + 3'd1;
                  end
               end
            endcase
         end
      end

      // End of input always finishes with an end record.
      if (eoi_ff) begin
         res[cnt[1:0]] = make_record(KIND_END, line_ff);
         cnt = cnt + 3'd1;
      end

      // Flag the final result of this request.
      if (cnt != 3'd0) begin
         res[cnt[1:0] - 2'd1].last = 1'b1;
      end
   end

   assign push.count = advance ? cnt[1:0] : 2'd0;
   assign push.items = res;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_IDLE;
         nlen_ff     <= '0;
         long_ff     <= 1'b0;
         acc_ff      <= '0;
         line_ff     <= '0;
         quote_ff    <= '0;
         esc_ff      <= 1'b0;
         fop_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            mode_ff  <= mode_in;
            nlen_ff  <= nlen_in;
            long_ff  <= long_in;
            acc_ff   <= acc_in;
            line_ff  <= line_in;
            quote_ff <= quote_in;
            esc_ff   <= esc_in;
            fop_ff   <= fop_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      char_ff <= char_in;
      eoi_ff  <= eoi_in;
      if (advance) begin
         nbuf_ff <= nbuf_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/stt_rsp_queue.sv
// ----------------------------------------------------------------------------
// stt_rsp_queue: result queue between the decoder and the response channel
// Takes up to three results per cycle, gives one per cycle when ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_rsp_queue import stt_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  push_type   push,
   output logic       room,
   stt_rsp_if.source  rsp_chan
);

   result_type             q_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wptr_ff, wptr_in;
   logic [QPTR_BITS-1:0]   rptr_ff, rptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   pop;
   result_type             head;

   assign room = (count_ff <= QCNT_BITS'(QUEUE_DEPTH - MAX_RESULTS));
   assign pop  = rsp_chan.valid && rsp_chan.ready;
   assign head = q_ff[rptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wptr_in  = wptr_ff + QPTR_BITS'(push.count);
      rptr_in  = rptr_ff + QPTR_BITS'(pop);
      count_in = count_ff + QCNT_BITS'(push.count) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Result storage, written at up to three consecutive slots.
   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (k < int'(push.count)) begin
            q_ff[wptr_ff + QPTR_BITS'(k)] <= push.items[k];
         end
      end
   end

   assign rsp_chan.valid         = (count_ff != '0);
   assign rsp_chan.is_token_end  = head.is_token_end;
   assign rsp_chan.text_byte     = head.text_byte;
   assign rsp_chan.token_kind    = head.token_kind;
   assign rsp_chan.keyword_index = head.keyword_index;
   assign rsp_chan.operator_code = head.operator_code;
   assign rsp_chan.bracket_code  = head.bracket_code;
   assign rsp_chan.number_value  = head.number_value;
   assign rsp_chan.radix_code    = head.radix_code;
   assign rsp_chan.line_number   = head.line_number;
   assign rsp_chan.last          = head.last;

endmodule

`default_nettype wire

>>> rtl/source_text_tokenizer_top.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_top: byte-serial source tokenizer
// Streams token text bytes and token records from a stream of source bytes.
// ----------------------------------------------------------------------------
// Each request carries one source byte or an end-of-input mark: it is
// registered, decoded combinationally and its up to three results go into an
// eight-entry result queue. A new request is accepted every cycle as long as
// the queue holds at most five results; the response side delivers one result
// per cycle while its ready is high, so the sustained rate is one request per
// cycle for requests that give at most one result and is set by the response
// port otherwise. A request passes the input register, then the result queue.
`default_nettype none

module source_text_tokenizer_top import stt_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   stt_req_if.sink    req_chan,
   stt_rsp_if.source  rsp_chan
);

   push_type push;
   logic     room;

   // Decoder with input register and scanner state.
   stt_lexer u_lexer (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .room     (room),
      .push     (push)
   );

   // Result queue feeding the response channel.
   stt_rsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

>>> dv/source_text_tokenizer_checker.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_checker: result predictor and scoreboard
// Watches the request and response channels of the tokenizer. Every accepted
// request is run through a behavioral model of the scanner; the predicted
// results are queued and compared field by field with the results the block
// delivers.
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer_checker import stt_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   stt_req_if        req_chan,
   stt_rsp_if        rsp_chan,
   output int        failures,
   output int        pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // Scanner state of the model.
   mode_type                   scan_mode;
   logic [7:0]                 name_chars [MAX_KEYWORD_LEN];
   int                         name_len;
   logic                       name_overflow;
   logic [NUMBER_BITS-1:0]     num_acc;
   logic [LINE_BITS-1:0]       line_cnt;
   logic [7:0]                 open_quote;
   logic                       in_escape;
   logic [7:0]                 op_first;

   result_type token_expect_q [$];
   result_type step_results [$];

   assign pending = token_expect_q.size();

   function automatic result_type rec_of(input logic [3:0] kind);
      result_type r;
      r = '0;
      r.is_token_end = 1'b1;
      r.token_kind   = kind;
      r.line_number  = line_cnt;
      return r;
   endfunction

   function automatic result_type text_of(input logic [7:0] c);
      result_type r;
      r = '0;
      r.text_byte = c;
      return r;
   endfunction

   function automatic result_type op_rec(input logic [4:0] code);
      result_type r;
      r = rec_of(KIND_OPER);
      r.operator_code = code;
      return r;
   endfunction

   function automatic result_type bracket_rec(input logic [2:0] code);
      result_type r;
      r = rec_of(KIND_BRACKET);
      r.bracket_code = code;
      return r;
   endfunction

   function automatic bit digit_c(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit alpha_c(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic [4:0] single_op(input logic [7:0] f);
      case (f)
         "&": return OP_AND;
         "|": return OP_OR;
         "-": return OP_MINUS;
         "+": return OP_PLUS;
         "*": return OP_MUL;
         "!": return OP_NOT;
         "<": return OP_LT;
         ">": return OP_GT;
         default: return OP_LAND;
      endcase
   endfunction

   // Returns the keyword index, or -1 when the name is no keyword.
   function automatic int match_keyword();
      string kw [KW_COUNT] = '{"defclass", "defun", "if", "for", "try", "while", "elif",
         "catch", "else", "endif", "endfor", "endtry", "endwhile", "endclass", "endfun",
         "in", "var", "isa", "return", "break"};
      bit ok;
      if (name_overflow || name_len == 0) return -1;
      for (int i = 0; i < KW_COUNT; i++) begin
         ok = (kw[i].len() == name_len);
         for (int j = 0; ok && j < name_len; j++)
            ok = (kw[i][j] == name_chars[j]);
         if (ok) return i;
      end
      return -1;
   endfunction

   task automatic close_token();
      result_type r;
      int k;
      case (scan_mode)
         MODE_IDENT: begin
            k = match_keyword();
            if (k >= 0) begin
               r = rec_of(KIND_KEYWORD);
               r.keyword_index = 5'(k);
               step_results.push_back(r);
            end else begin
               step_results.push_back(rec_of(KIND_IDENT));
            end
         end
         MODE_ZERO, MODE_DEC: begin
            r = rec_of(KIND_DECIMAL);
            r.number_value = num_acc;
            step_results.push_back(r);
         end
         MODE_REAL: step_results.push_back(rec_of(KIND_REAL));
         MODE_HEX, MODE_OCT, MODE_BIN: begin
            r = rec_of(KIND_RADIX);
            r.radix_code = (scan_mode == MODE_HEX) ? RADIX_HEX :
                           (scan_mode == MODE_OCT) ? RADIX_OCT : RADIX_BIN;
            step_results.push_back(r);
         end
         MODE_STR: begin
            if (in_escape) step_results.push_back(text_of("\\"));
            step_results.push_back(rec_of(KIND_STRING));
         end
         MODE_OP: begin
            if (op_first == "=") step_results.push_back(rec_of(KIND_ASSIGN));
            else step_results.push_back(op_rec(single_op(op_first)));
         end
         default: ;
      endcase
      scan_mode = MODE_IDLE;
      in_escape = 1'b0;
   endtask

   // First byte of a token, or a byte between tokens.
   task automatic begin_token(input logic [7:0] c);
      scan_mode = MODE_IDLE;
      if (c == 8'd10) begin
         line_cnt++;
         return;
      end
      if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
      case (c)
         "&", "|", "-", "+", "*", "!", "<", ">", "=": begin
            op_first = c;
            scan_mode = MODE_OP;
         end
         "/": step_results.push_back(op_rec(OP_DIV));
         "%": step_results.push_back(op_rec(OP_MOD));
         "~": step_results.push_back(op_rec(OP_TILDE));
         "^": step_results.push_back(op_rec(OP_XOR));
         "[": step_results.push_back(bracket_rec(BR_LSQ));
         "]": step_results.push_back(bracket_rec(BR_RSQ));
         "(": step_results.push_back(bracket_rec(BR_LPAR));
         ")": step_results.push_back(bracket_rec(BR_RPAR));
         "{": step_results.push_back(bracket_rec(BR_LCUR));
         "}": step_results.push_back(bracket_rec(BR_RCUR));
         "\"", "'": begin
            open_quote = c;
            in_escape = 1'b0;
            scan_mode = MODE_STR;
         end
         default: begin
            step_results.push_back(text_of(c));
            if (digit_c(c)) begin
               num_acc = NUMBER_BITS'(c - "0");
               scan_mode = (c == "0") ? MODE_ZERO : MODE_DEC;
            end else if (alpha_c(c)) begin
               name_chars[0] = c;
               name_len = 1;
               name_overflow = 1'b0;
               scan_mode = MODE_IDENT;
            end else begin
               step_results.push_back(rec_of(KIND_UNKNOWN));
            end
         end
      endcase
   endtask

   task automatic scan_byte(input logic [7:0] c);
      logic [7:0] esc;
      logic [NUMBER_BITS-1:0] d;
      bit hit;
      logic [4:0] code;
      case (scan_mode)
         MODE_IDENT: begin
            if (alpha_c(c) || digit_c(c)) begin
               step_results.push_back(text_of(c));
               if (name_len < MAX_KEYWORD_LEN) name_chars[name_len++] = c;
               else name_overflow = 1'b1;
            end else if (c == ":") begin
               step_results.push_back(text_of(c));
               step_results.push_back(rec_of(KIND_PARAM));
               scan_mode = MODE_IDLE;
            end else begin
               close_token();
               begin_token(c);
            end
         end
         MODE_ZERO: begin
            if (c == "x") scan_mode = MODE_HEX;
            else if (c == "b") scan_mode = MODE_BIN;
            else if (c >= "0" && c <= "7") scan_mode = MODE_OCT;
            else if (c == ".") scan_mode = MODE_REAL;
            if (scan_mode != MODE_ZERO) begin
               step_results.push_back(text_of(c));
            end else begin
               close_token();
               begin_token(c);
            end
         end
         MODE_DEC: begin
            if (digit_c(c)) begin
               step_results.push_back(text_of(c));
               d = NUMBER_BITS'(c - "0");
               if (num_acc > (NUMBER_MAX - d) / 10) num_acc = NUMBER_MAX;
               else num_acc = num_acc * 10 + d;
            end else if (c == ".") begin
               step_results.push_back(text_of(c));
               scan_mode = MODE_REAL;
            end else begin
               close_token();
               begin_token(c);
            end
         end
         MODE_REAL, MODE_HEX, MODE_OCT, MODE_BIN: begin
            if (scan_mode == MODE_REAL) hit = digit_c(c);
            else if (scan_mode == MODE_HEX)
               hit = digit_c(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
            else if (scan_mode == MODE_OCT) hit = c >= "0" && c <= "7";
            else hit = c == "0" || c == "1";
            if (hit) begin
               step_results.push_back(text_of(c));
            end else begin
               close_token();
               begin_token(c);
            end
         end
         MODE_STR: begin
            if (in_escape) begin
               in_escape = 1'b0;
               case (c)
                  "a": esc = 8'd7;
                  "b": esc = 8'd8;
                  "e": esc = 8'd27;
                  "f": esc = 8'd12;
                  "n": esc = 8'd10;
                  "r": esc = 8'd13;
                  "t": esc = 8'd9;
                  "v": esc = 8'd11;
                  default: esc = c;
               endcase
               step_results.push_back(text_of(esc));
            end else if (c == open_quote) begin
               step_results.push_back(rec_of(KIND_STRING));
               scan_mode = MODE_IDLE;
            end else if (open_quote == "\"" && c == "\\") begin
               in_escape = 1'b1;
            end else begin
               step_results.push_back(text_of(c));
            end
         end
         MODE_OP: begin
            hit = 1'b0;
            code = OP_LAND;
            case (op_first)
               "&": begin hit = c == "&"; code = OP_LAND; end
               "|": begin hit = c == "|"; code = OP_LOR; end
               "-": begin hit = c == "-"; code = OP_DEC; end
               "+": begin hit = c == "+"; code = OP_INC; end
               "*": begin hit = c == "*"; code = OP_POW; end
               "!": begin hit = c == "="; code = OP_NE; end
               "=": begin hit = c == "="; code = OP_EQ; end
               "<": begin hit = c == "=" || c == "<"; code = (c == "=") ? OP_LE : OP_SHL; end
               ">": begin hit = c == "=" || c == ">"; code = (c == "=") ? OP_GE : OP_SHR; end
               default: ;
            endcase
            if (hit) begin
               step_results.push_back(op_rec(code));
               scan_mode = MODE_IDLE;
            end else begin
               close_token();
               begin_token(c);
            end
         end
         default: begin_token(c);
      endcase
   endtask

   // Predict the results of one accepted request and queue them.
   task automatic predict_request(input logic [7:0] c, input logic eoi);
      step_results.delete();
      if (eoi) begin
         close_token();
         step_results.push_back(rec_of(KIND_END));
      end else begin
         scan_byte(c);
      end
      if (step_results.size() > 0) step_results[$].last = 1'b1;
      foreach (step_results[i]) token_expect_q.push_back(step_results[i]);
   endtask

   task automatic compare_result();
      result_type got, want;
      got = '{rsp_chan.is_token_end, rsp_chan.text_byte, rsp_chan.token_kind,
              rsp_chan.keyword_index, rsp_chan.operator_code, rsp_chan.bracket_code,
              rsp_chan.number_value, rsp_chan.radix_code, rsp_chan.line_number,
              rsp_chan.last};
      if (token_expect_q.size() == 0) begin
         failures++;
         if (failures <= 10) $display("ERROR: unexpected result %h", got);
         return;
      end
      want = token_expect_q.pop_front();
      if (got !== want) begin
         failures++;
         if (failures <= 10)
            $display("ERROR: result mismatch, expected %p, actual %p", want, got);
      end
   endtask

   // Requests are predicted and results checked at each rising edge.
   always @(posedge clock) begin
      if (reset) begin
         scan_mode     = MODE_IDLE;
         name_len      = 0;
         name_overflow = 1'b0;
         num_acc       = '0;
         line_cnt      = '0;
         open_quote    = '0;
         in_escape     = 1'b0;
         op_first      = '0;
         token_expect_q.delete();
      end else begin
         if (req_chan.valid && req_chan.ready)
            predict_request(req_chan.char_byte, req_chan.end_of_input);
         if (rsp_chan.valid && rsp_chan.ready) compare_result();
      end
   end

   initial failures = 0;

endmodule

`default_nettype wire

>>> dv/source_text_tokenizer_top_tb.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_top_tb: testbench top of the source tokenizer
// Sends a directed source text and then random token sequences with random
// idle bursts on both channels, including one long response stall, and
// reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;
   int   failures;
   int   pending;
   bit   quiet_phase;
   bit   hold_rsp;

   stt_req_if req_chan ();
   stt_rsp_if rsp_chan ();

   source_text_tokenizer_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   source_text_tokenizer_checker checker_inst (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .failures (failures),
      .pending  (pending)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Send one request, maybe after an idle burst, and wait until it is accepted.
   // The request stays valid after acceptance until the next call replaces it
   // or opens an idle burst, so valid changes at most once per falling edge.
   task automatic send_request(input logic [7:0] c, input logic eoi);
      int gap;
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 7);
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.char_byte    <= c;
      req_chan.end_of_input <= eoi;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_request(s[i], 1'b0);
   endtask

   function automatic string rand_chars(input string pool, input int n);
      string s;
      s = "";
      for (int i = 0; i < n; i++) s = {s, pool[$urandom_range(0, pool.len() - 1)]};
      return s;
   endfunction

   // One random well-formed token followed by a separator, or one stray byte.
   function automatic string rand_token();
      string kws [6] = '{"defclass", "endwhile", "if", "return", "in", "isa"};
      string ops [12] = '{"&&", "||", "--", "++", "**", "!=", "<=", "<<", ">=", ">>", "==", "="};
      string alnum, seps;
      alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
      seps  = " \n\t()[]{};,";
      case ($urandom_range(0, 11))
         0: return {kws[$urandom_range(0, 5)], rand_chars(seps, 1)};
         1: return {rand_chars("abcxyzQ", 1), rand_chars(alnum, $urandom_range(0, 11)), " "};
         2: return {rand_chars("pq", 1), rand_chars(alnum, 2), ": "};
         3: return {rand_chars("123456789", 1), rand_chars("0123456789", $urandom_range(0, 12)), " "};
         4: return {"0x", rand_chars("0123456789abcdefABCDEF", $urandom_range(0, 4)), " "};
         5: return {"0b", rand_chars("01", $urandom_range(0, 5)), ";"};
         6: return {"0", rand_chars("01234567", $urandom_range(1, 3)), " "};
         7: return {rand_chars("0123", 1), ".", rand_chars("0123456789", 2), " "};
         8: return {"\"", rand_chars("ab \\n\\t\\\"x", $urandom_range(0, 5)), "\" "};
         9: return {"'", rand_chars("ab \n\\\"", $urandom_range(0, 4)), "' "};
         10: return {ops[$urandom_range(0, 11)], rand_chars("&|-+*!<>=/%~^ a1", 1)};
         default: return rand_chars("@#$`?\\:.,;", 1);
      endcase
   endfunction

   // Response side: random stall bursts, one long hold-off, none at the end.
   initial begin
      int gap;
      rsp_chan.ready <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (60) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Run limit.
   initial begin
      #2ms;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      string item;
      int sent, waited;
      bit stall_done;
      req_chan.valid        <= 1'b0;
      req_chan.char_byte    <= '0;
      req_chan.end_of_input <= 1'b0;
      quiet_phase = 1'b0;
      hold_rsp    = 1'b0;
      stall_done  = 1'b0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: keywords, saturation, radix edges, escapes, operators.
      send_text("endwhile defclasss x:99999999999 08 0x 0b 0. 017 <<>>=!");
      send_text("\"\"\"a\\e\\q\"'\\n' ^%~/[](){}");
      send_request(8'd255, 1'b0);
      send_request(8'd0, 1'b0);
      send_request(8'd128, 1'b0);
      send_text("\"z\\");
      send_request(8'd0, 1'b1);
      send_request(8'd0, 1'b1);
      send_text("=");
      send_request(8'd0, 1'b1);

      // Random part: mostly token sequences, some raw byte noise.
      sent = 0;
      while (sent < 320) begin
         if (sent > 260) quiet_phase = 1'b1;
         if (sent > 150 && !stall_done) begin
            hold_rsp   = 1'b1;
            stall_done = 1'b1;
         end
         if ($urandom_range(0, 9) == 0) begin
            send_request(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            sent++;
         end else begin
            item = rand_token();
            send_text(item);
            sent += item.len();
         end
      end
      send_request(8'd0, 1'b1);
      req_chan.valid <= 1'b0;

      // Drain, then allow the pipeline latency to settle.
      waited = 0;
      while (pending != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
